// File: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants for the bitmap first-fit allocator
// Field widths, request and status codes, register map and FSM states.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 8192;
  localparam int unsigned WORD_BITS_DEF   = 32;

  localparam int unsigned FIELD_W    = 14;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [FIELD_W-1:0] POOL_SIZE_RST = 14'd8192;

  // register index, taken from paddr[2]
  localparam logic REG_INODE_SIZE = 1'b0;
  localparam logic REG_BLOCK_SIZE = 1'b1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic POOL_INODE = 1'b0;
  localparam logic POOL_BLOCK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// File: design/bfa_req_if.sv
// ----------------------------------------------------------------------------
// bfa_req_if: request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic                        pool;
  logic [bfa_pkg::FIELD_W-1:0] number;

  modport source (output valid, func, pool, number, input ready);
  modport sink   (input valid, func, pool, number, output ready);
endinterface

// File: design/bfa_rsp_if.sv
// ----------------------------------------------------------------------------
// bfa_rsp_if: response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::FIELD_W-1:0] granted_number;
  bfa_pkg::status_e            status;
  logic [bfa_pkg::FIELD_W-1:0] free_count;

  modport source (output valid, granted_number, status, free_count, input ready);
  modport sink   (input valid, granted_number, status, free_count, output ready);
endinterface

// File: design/bitmap_first_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core: two-pool bitmap first-fit allocator
// Flow: a request scans bitmap words from word 0; an allocate ends at the first word
//   with a clear bit in the pool, a free at its number's word; rejects skip the scan.
// Flow control: one request at a time; request ready is high only in idle.
// Reset: config set to full pools, counters cleared, then a clearing pass writes
//   2*2^WRD_W rows (512 at default sizes) before the first request beat.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_core #(
  parameter int unsigned MAX_ENTRIES = bfa_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned WORD_BITS   = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bfa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bfa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  bfa_req_if.sink                        req_i,
  bfa_rsp_if.source                      rsp_o
);

  localparam int unsigned MAP_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WRD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned ROW_W     = WRD_W + 1;
  localparam int unsigned MEM_ROWS  = 2 ** ROW_W;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SPAN_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int unsigned CMP_W     = (CNT_W > bfa_pkg::FIELD_W) ? CNT_W : bfa_pkg::FIELD_W;
  localparam int unsigned FW        = bfa_pkg::FIELD_W;

  // config registers
  logic [FW-1:0]    inode_cfg_q, block_cfg_q;
  logic [CNT_W-1:0] inode_size, block_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_cfg_q <= bfa_pkg::POOL_SIZE_RST;
      block_cfg_q <= bfa_pkg::POOL_SIZE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == bfa_pkg::REG_BLOCK_SIZE) begin
        block_cfg_q <= pwdata[FW-1:0];
      end else begin
        inode_cfg_q <= pwdata[FW-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bfa_pkg::REG_BLOCK_SIZE) ?
                  bfa_pkg::APB_DATA_W'(block_cfg_q) : bfa_pkg::APB_DATA_W'(inode_cfg_q);

  assign inode_size = (CMP_W'(inode_cfg_q) > CMP_W'(MAX_ENTRIES)) ?
                      CNT_W'(MAX_ENTRIES) : CNT_W'(inode_cfg_q);
  assign block_size = (CMP_W'(block_cfg_q) > CMP_W'(MAX_ENTRIES)) ?
                      CNT_W'(MAX_ENTRIES) : CNT_W'(block_cfg_q);

  // bitmap memory, row = {pool, word}
  logic [WORD_BITS-1:0] mem_q [MEM_ROWS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ROW_W-1:0]     mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // control state
  bfa_pkg::state_e  state_q, state_d;
  logic [ROW_W-1:0] clr_q, clr_d;
  logic             ev_vld_q, ev_vld_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [CNT_W-1:0] inode_used_q, inode_used_d, block_used_q, block_used_d;

  // request context and scan datapath
  logic              func_q, func_d, pool_q, pool_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic [WRD_W-1:0]  scan_q, scan_d, ev_word_q, ev_word_d;
  logic [SPAN_W-1:0] scan_rem_q, scan_rem_d, ev_rem_q, ev_rem_d;
  logic [SPAN_W-1:0] scan_base_q, scan_base_d, ev_base_q, ev_base_d;
  logic [FW-1:0]     res_granted_q, res_granted_d;
  bfa_pkg::status_e  res_status_q, res_status_d;
  logic [FW-1:0]     rsp_granted_q, rsp_granted_d, rsp_free_q, rsp_free_d;
  bfa_pkg::status_e  rsp_status_q, rsp_status_d;

  // lowest clear bit inside the pool in the word under evaluation
  logic [WORD_BITS-1:0] avail;
  logic                 found;
  logic [BIT_W-1:0]     low_idx;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = ~rdata_q[b] && (SPAN_W'(b) < ev_rem_q);
    end
    found   = |avail;
    low_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        low_idx = BIT_W'(b);
      end
    end
  end

  logic [CNT_W-1:0]  used_sel;
  logic [CNT_W-1:0]  size_sel;
  logic [BIT_W-1:0]  free_bit;
  logic [WORD_BITS-1:0] one_hot_alloc, one_hot_free;

  assign used_sel      = (pool_q == bfa_pkg::POOL_BLOCK) ? block_used_q : inode_used_q;
  assign size_sel      = (req_i.pool == bfa_pkg::POOL_BLOCK) ? block_size : inode_size;
  assign free_bit      = ev_rem_q[BIT_W-1:0];
  assign one_hot_alloc = WORD_BITS'(1) << low_idx;
  assign one_hot_free  = WORD_BITS'(1) << free_bit;
  assign mem_raddr     = {pool_q, scan_q};
  assign req_i.ready   = (state_q == bfa_pkg::ST_IDLE);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    ev_vld_d      = 1'b0;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    inode_used_d  = inode_used_q;
    block_used_d  = block_used_q;
    func_d        = func_q;
    pool_d        = pool_q;
    size_d        = size_q;
    scan_d        = scan_q;
    scan_rem_d    = scan_rem_q;
    scan_base_d   = scan_base_q;
    ev_word_d     = scan_q;
    ev_rem_d      = scan_rem_q;
    ev_base_d     = scan_base_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    rsp_granted_d = rsp_granted_q;
    rsp_status_d  = rsp_status_q;
    rsp_free_d    = rsp_free_q;
    mem_we        = 1'b0;
    mem_waddr     = {pool_q, ev_word_q};
    mem_wdata     = rdata_q;

    unique case (state_q)
      bfa_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = bfa_pkg::ST_IDLE;
        end
      end
      bfa_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          func_d        = req_i.func;
          pool_d        = req_i.pool;
          size_d        = size_sel;
          scan_d        = '0;
          scan_base_d   = '0;
          res_granted_d = '0;
          res_status_d  = bfa_pkg::STATUS_OK;
          state_d       = bfa_pkg::ST_SCAN;
          if (req_i.func == bfa_pkg::FUNC_ALLOC) begin
            scan_rem_d = SPAN_W'(size_sel);
            if (size_sel == '0) begin
              res_status_d = bfa_pkg::STATUS_FULL;
              state_d      = bfa_pkg::ST_DONE;
            end
          end else begin
            scan_rem_d = SPAN_W'(req_i.number) - 1'b1;
            if (req_i.number == '0 || CMP_W'(req_i.number) > CMP_W'(size_sel)) begin
              res_status_d = bfa_pkg::STATUS_RANGE;
              state_d      = bfa_pkg::ST_DONE;
            end
          end
        end
      end
      bfa_pkg::ST_SCAN: begin
        ev_vld_d    = 1'b1;
        scan_base_d = scan_base_q + SPAN_W'(WORD_BITS);
        scan_rem_d  = (scan_rem_q > SPAN_W'(WORD_BITS)) ?
                      scan_rem_q - SPAN_W'(WORD_BITS) : '0;
        if (scan_q != WRD_W'(MAP_WORDS - 1)) begin
          scan_d = scan_q + 1'b1;
        end
        if (ev_vld_q) begin
          if (func_q == bfa_pkg::FUNC_ALLOC) begin
            if (found) begin
              mem_we        = 1'b1;
              mem_wdata     = rdata_q | one_hot_alloc;
              res_granted_d = FW'(ev_base_q + SPAN_W'(low_idx) + 1'b1);
              state_d       = bfa_pkg::ST_DONE;
              if (used_sel < CNT_W'(MAX_ENTRIES)) begin
                if (pool_q == bfa_pkg::POOL_BLOCK) begin
                  block_used_d = block_used_q + 1'b1;
                end else begin
                  inode_used_d = inode_used_q + 1'b1;
                end
              end
            end else if (ev_rem_q <= SPAN_W'(WORD_BITS)) begin
              res_status_d = bfa_pkg::STATUS_FULL;
              state_d      = bfa_pkg::ST_DONE;
            end
          end else if (ev_rem_q < SPAN_W'(WORD_BITS)) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q & ~one_hot_free;
            state_d   = bfa_pkg::ST_DONE;
            if (used_sel != '0) begin
              if (pool_q == bfa_pkg::POOL_BLOCK) begin
                block_used_d = block_used_q - 1'b1;
              end else begin
                inode_used_d = inode_used_q - 1'b1;
              end
            end
          end
        end
      end
      bfa_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d   = 1'b1;
          rsp_granted_d = res_granted_q;
          rsp_status_d  = res_status_q;
          rsp_free_d    = (used_sel >= size_q) ? '0 : FW'(size_q - used_sel);
          state_d       = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfa_pkg::ST_CLEAR;
      clr_q        <= '0;
      ev_vld_q     <= 1'b0;
      rsp_valid_q  <= 1'b0;
      inode_used_q <= '0;
      block_used_q <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      ev_vld_q     <= ev_vld_d;
      rsp_valid_q  <= rsp_valid_d;
      inode_used_q <= inode_used_d;
      block_used_q <= block_used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q        <= func_d;
    pool_q        <= pool_d;
    size_q        <= size_d;
    scan_q        <= scan_d;
    scan_rem_q    <= scan_rem_d;
    scan_base_q   <= scan_base_d;
    ev_word_q     <= ev_word_d;
    ev_rem_q      <= ev_rem_d;
    ev_base_q     <= ev_base_d;
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
    rsp_granted_q <= rsp_granted_d;
    rsp_status_q  <= rsp_status_d;
    rsp_free_q    <= rsp_free_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.granted_number = rsp_granted_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.free_count     = rsp_free_q;

endmodule
